// ----- design/werm_pkg.sv -----
// ----------------------------------------------------------------------------
// werm_pkg
// Shared types and constants of the windowed event rate monitor.
// ----------------------------------------------------------------------------
package werm_pkg;

    localparam int CAPACITY     = 1000;
    localparam int SLOT_W       = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int STAMP_W      = 27;
    localparam int EXEC_W       = 16;
    localparam int RATE_W       = 28;
    localparam int TOTAL_W      = 32;
    localparam int SUM_W        = EXEC_W + CNT_W;
    localparam int NUM_W        = CNT_W + 18;
    localparam int QUO_W        = NUM_W;
    localparam int DIV_W        = (SUM_W > NUM_W) ? SUM_W : NUM_W;
    localparam int DIV_CNT_W    = $clog2(DIV_W + 1);

    localparam logic [STAMP_W-1:0] WINDOW_RESET = STAMP_W'(10000);
    localparam logic [RATE_W-1:0]  RATE_MAX     = {RATE_W{1'b1}};
    localparam logic [17:0]        MS_PER_S_Q8  = 18'd256000;

    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic                 func;
        logic [STAMP_W-1:0]   stamp_ms;
        logic [EXEC_W-1:0]    exec_ms;
    } t_in;

    typedef struct packed {
        logic [RATE_W-1:0]    rate_q8;
        logic [EXEC_W-1:0]    avg_exec_ms;
        logic [EXEC_W-1:0]    max_exec_ms;
        logic [TOTAL_W-1:0]   total_events;
        logic [CNT_W-1:0]     stored_events;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input item
        logic record;      // write event
        logic rd_issue;    // issue read of walk index
        logic rd_use;      // consume read data of previous issue
        logic rd_span;     // read address is the start stamp slot
        logic rd_newest;   // read data is the start stamp
        logic div_start;   // start division
        logic div_sel;     // 0 average, 1 rate
        logic div_take;    // capture quotient
        logic out_load;    // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
        logic walk_last;   // issued index is the last
        logic empty;
        logic div_busy;
    } t_sts;

    function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] a,
                                                   logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(CAPACITY)) begin
            s = s - (CNT_W+1)'(CAPACITY);
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage

// ----- design/werm_if.sv -----
// ----------------------------------------------------------------------------
// werm_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface werm_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/werm_ram.sv -----
// ----------------------------------------------------------------------------
// werm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module werm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/werm_div.sv -----
// ----------------------------------------------------------------------------
// werm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module werm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [werm_pkg::DIV_W-1:0]    i_num,
    input  logic [werm_pkg::STAMP_W-1:0]  i_den,
    output logic                          o_busy,
    output logic [werm_pkg::DIV_W-1:0]    o_quo
);
    import werm_pkg::*;

    logic [DIV_W-1:0]     r_quo;
    logic [STAMP_W:0]     r_rem;
    logic [STAMP_W-1:0]   r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [STAMP_W:0]     w_trial;

    assign w_trial = {r_rem[STAMP_W-1:0], r_quo[DIV_W-1]};
    assign o_busy  = (r_cnt != '0);
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (o_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= w_trial - {1'b0, r_den};
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end
endmodule

// ----- design/werm_dp.sv -----
// ----------------------------------------------------------------------------
// werm_dp
// Datapath: event stores, walk pointers, accumulators, divider and output.
// ----------------------------------------------------------------------------
module werm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  werm_pkg::t_in                 i_item,
    input  logic [werm_pkg::STAMP_W-1:0]  i_window,
    input  werm_pkg::t_cmd                i_cmd,
    output werm_pkg::t_sts                o_sts,
    output werm_pkg::t_out                o_res
);
    import werm_pkg::*;

    t_in                r_item;
    logic [SLOT_W-1:0]  r_oldest;
    logic [CNT_W-1:0]   r_fill;
    logic [TOTAL_W-1:0] r_total;

    logic [CNT_W-1:0]   r_idx;       // logical index of next read
    logic [CNT_W-1:0]   r_pidx;      // logical index of data arriving
    logic               r_inwin;     // still counting from newest
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_sum;
    logic [EXEC_W-1:0]  r_max;
    logic [CNT_W-1:0]   r_start;
    logic [STAMP_W-1:0] r_newest;
    logic [STAMP_W-1:0] r_first;
    logic [EXEC_W-1:0]  r_avg;
    t_out               r_res;

    logic               w_we;
    logic [SLOT_W-1:0]  w_waddr;
    logic [SLOT_W-1:0]  w_raddr;
    logic [STAMP_W-1:0] w_rstamp;
    logic [EXEC_W-1:0]  w_rexec;
    logic signed [STAMP_W+1:0] w_age;
    logic               w_old;
    logic signed [STAMP_W+1:0] w_span;
    logic [DIV_W-1:0]   w_num;
    logic [STAMP_W-1:0] w_den;
    logic               w_div_busy;
    logic [DIV_W-1:0]   w_quo;
    logic               w_rate_ok;
    logic [RATE_W-1:0]  w_rate;

    assign w_we    = i_cmd.record;
    assign w_waddr = (r_fill < CNT_W'(CAPACITY)) ? slot_add(r_oldest, r_fill) : r_oldest;
    assign w_raddr = i_cmd.rd_span ? slot_add(r_oldest, r_start) : slot_add(r_oldest, r_idx);

    werm_ram #(.WIDTH(STAMP_W), .DEPTH(CAPACITY)) u_stamp (
        .i_clk  (i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_item.stamp_ms),
        .i_raddr(w_raddr), .o_rdata(w_rstamp)
    );
    werm_ram #(.WIDTH(EXEC_W), .DEPTH(CAPACITY)) u_exec (
        .i_clk  (i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_item.exec_ms),
        .i_raddr(w_raddr), .o_rdata(w_rexec)
    );

    assign w_age  = $signed({2'b00, r_item.stamp_ms}) - $signed({2'b00, w_rstamp});
    assign w_old  = w_age > $signed({2'b00, i_window});
    assign w_span = $signed({2'b00, r_newest}) - $signed({2'b00, r_first});
    assign w_rate_ok = (r_count != '0) && ((r_fill - 1'b1) > r_start);
    assign w_num  = i_cmd.div_sel ? DIV_W'(r_count) * DIV_W'(MS_PER_S_Q8) : DIV_W'(r_sum);
    assign w_den  = i_cmd.div_sel ? w_span[STAMP_W-1:0] : STAMP_W'(r_count);
    assign w_rate = (w_quo > DIV_W'(RATE_MAX)) ? RATE_MAX : w_quo[RATE_W-1:0];

    werm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(w_num), .i_den(w_den), .o_busy(w_div_busy), .o_quo(w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_fill   <= '0;
            r_total  <= '0;
        end else if (i_cmd.record) begin
            if (r_fill < CNT_W'(CAPACITY)) begin
                r_fill <= r_fill + 1'b1;
            end else begin
                r_oldest <= slot_add(r_oldest, CNT_W'(1));
            end
            if (r_total != '1) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_item;
            r_idx   <= r_fill - 1'b1;
            r_inwin <= 1'b1;
            r_count <= '0;
            r_sum   <= '0;
            r_max   <= '0;
            r_start <= '0;
        end
        if (i_cmd.rd_issue) begin
            r_pidx <= r_idx;
            r_idx  <= r_idx - 1'b1;
        end
        if (i_cmd.rd_use) begin
            if (r_pidx == r_fill - 1'b1) begin
                r_newest <= w_rstamp;
            end
            if (w_rexec > r_max) begin
                r_max <= w_rexec;
            end
            if (r_inwin) begin
                if (w_old) begin
                    r_inwin <= 1'b0;
                    r_start <= r_pidx;
                end else begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + SUM_W'(w_rexec);
                end
            end
        end
        if (i_cmd.rd_newest) begin
            r_first <= w_rstamp;
        end
        if (i_cmd.div_take) begin
            r_avg <= (r_count == '0) ? '0 : w_quo[EXEC_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_res.avg_exec_ms   <= r_avg;
            r_res.max_exec_ms   <= r_max;
            r_res.total_events  <= r_total;
            r_res.stored_events <= r_fill;
            if (!w_rate_ok) begin
                r_res.rate_q8 <= '0;
            end else if (w_span <= 0) begin
                r_res.rate_q8 <= RATE_MAX;
            end else begin
                r_res.rate_q8 <= w_rate;
            end
        end
    end

    assign o_sts.is_query  = (r_item.func == FUNC_QUERY);
    assign o_sts.walk_last = (r_idx == '0);
    assign o_sts.empty     = (r_fill == '0);
    assign o_sts.div_busy  = w_div_busy;
    assign o_res           = r_res;

`ifndef SYNTH
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY)) else $error("fill above capacity");
    a_oldest_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != CNT_W'(CAPACITY) |-> r_oldest == '0) else $error("oldest moved early");
    a_count_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_use |-> r_count < r_fill) else $error("count above fill");
`endif
endmodule

// ----- design/werm_ctrl.sv -----
// ----------------------------------------------------------------------------
// werm_ctrl
// Controller: sequences record, store walk, divisions and result transfer.
// ----------------------------------------------------------------------------
module werm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  werm_pkg::t_sts  i_sts,
    output werm_pkg::t_cmd  o_cmd
);
    import werm_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DEC   = 9'b000000010,
        S_WALK  = 9'b000000100,
        S_DRAIN = 9'b000001000,
        S_SPAN  = 9'b000010000,
        S_SPAND = 9'b000100000,
        S_DAVG  = 9'b001000000,
        S_DRATE = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_div_go, n_div_go;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_div_go    = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (!i_sts.is_query) begin
                    o_cmd.record = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_sts.empty) begin
                    n_state = S_DAVG;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = i_sts.walk_last ? S_DRAIN : S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.rd_use   = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.rd_use  = 1'b1;
                o_cmd.rd_span = 1'b1;
                n_state       = S_SPAN;
            end
            S_SPAN: begin
                o_cmd.rd_span = 1'b1;
                n_state       = S_SPAND;
            end
            S_SPAND: begin
                o_cmd.rd_newest = 1'b1;
                n_state         = S_DAVG;
            end
            S_DAVG: begin
                if (!r_div_go && !i_sts.div_busy) begin
                    o_cmd.div_start = 1'b1;
                    n_div_go        = 1'b1;
                end else if (r_div_go || i_sts.div_busy) begin
                    n_div_go = 1'b0;
                    if (!i_sts.div_busy && !r_div_go) begin
                        n_state = S_DRATE;
                    end
                end
                if (!r_div_go && !i_sts.div_busy && o_cmd.div_start == 1'b0) begin
                    n_state = S_DRATE;
                end
                if (r_div_go == 1'b0 && i_sts.div_busy) begin
                    n_div_go = 1'b1;
                end
                if (r_div_go && !i_sts.div_busy) begin
                    o_cmd.div_take  = 1'b1;
                    o_cmd.div_sel   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_div_go        = 1'b0;
                    n_state         = S_DRATE;
                end
            end
            S_DRATE: begin
                o_cmd.div_sel = 1'b1;
                if (!i_sts.div_busy && !r_div_go) begin
                    n_div_go = 1'b1;
                end
                if (r_div_go && !(r_out_valid && !i_out_ready)) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_div_go       = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_div_go    <= n_div_go;
        end
    end

`ifndef SYNTH
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.div_busy) else $error("output during divide");
    a_rec_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.record |=> r_state == S_IDLE) else $error("record not closed");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> $past(r_state) == S_IDLE || r_state == S_IDLE)
        else $error("load outside idle");
`endif
endmodule

// ----- design/windowed_event_rate_monitor.sv -----
// ----------------------------------------------------------------------------
// windowed_event_rate_monitor
// Keeps the newest timer events and reports windowed rate and statistics.
//
// Channels: in_ch carries func, stamp_ms, exec_ms; out_ch carries one result
// per query (none for a record). cfg_we / cfg_wdata write window_ms.
// A record is written in S_DEC, which then returns to S_IDLE for the next
// input. A query walks the store once, newest to oldest, through the
// registered read port of the event memory (no walk for an empty store),
// then runs two serial divisions. The result is loaded and made valid as
// the controller returns to S_IDLE, where the next input may be taken.
// The memory read port and the one-bit divider set the length of a query.
// Reset clears the counts and the oldest pointer and sets window_ms to 10000;
// the event memory is not cleared, stored entries are tracked by the fill
// count. A finished result waits in the output register; while the receiver
// stalls, the next item may still enter, and a second result waits for the
// first to be taken.
// ----------------------------------------------------------------------------
module windowed_event_rate_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          cfg_we,
    input  logic [werm_pkg::STAMP_W-1:0]  cfg_wdata,
    werm_if.sink                          in_ch,
    werm_if.source                        out_ch
);
    import werm_pkg::*;

    logic [STAMP_W-1:0] r_window;
    t_cmd               w_cmd;
    t_sts               w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (cfg_we) begin
            r_window <= cfg_wdata;
        end
    end

    werm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    werm_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(in_ch.data), .i_window(r_window),
        .i_cmd(w_cmd), .o_sts(w_sts), .o_res(out_ch.data)
    );
endmodule
